[src/gb3_pkg.sv]
// ----------------------------------------------------------------------------
// gb3_pkg - shared types and constants for the 3x3 Gaussian blur
// Register codes, reset values, weight bundle and window type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gb3_pkg;

    // pixel and field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int WGT_W      = 16;
    localparam int FW_W       = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // line buffer word: two stored rows of one column
    localparam int LB_W       = 2 * PIX_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_CENTRE = 3'd2,
        CFG_SIDE   = 3'd3,
        CFG_CORNER = 3'd4
    } t_cfg_idx;

    // register values after reset
    localparam logic [FW_W-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd480;
    localparam logic [WGT_W-1:0] RST_CENTRE = 16'd10430;
    localparam logic [WGT_W-1:0] RST_SIDE   = 16'd6326;
    localparam logic [WGT_W-1:0] RST_CORNER = 16'd3837;

    // operation code of an input transfer
    localparam logic OP_DRAIN = 1'b1;

    // largest grey level
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Q0.16 kernel weights
    typedef struct packed {
        logic [WGT_W-1:0] centre;
        logic [WGT_W-1:0] side;
        logic [WGT_W-1:0] corner;
    } t_weights;

    // one column of the window: [0] top, [1] middle, [2] bottom
    typedef logic [2:0][PIX_W-1:0] t_triple;

    // nine taps in raster order plus the end-of-frame mark
    typedef struct packed {
        logic [8:0][PIX_W-1:0] tap;
        logic                  last;
    } t_window;

endpackage

`default_nettype wire

[src/gb3_cfg.sv]
// ----------------------------------------------------------------------------
// gb3_cfg - configuration registers
// Holds frame size and weights, derives the last column and last row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gb3_cfg
    import gb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [COL_W-1:0]           o_w_last,
    output logic [ROW_W-1:0]           o_h_last,
    output t_weights                   o_weights
);

    logic [FW_W-1:0]  r_width;
    logic [ROW_W-1:0] r_height;
    t_weights         r_weights;

    assign o_cfg_ready = 1'b1;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width          <= RST_WIDTH;
            r_height         <= RST_HEIGHT;
            r_weights.centre <= RST_CENTRE;
            r_weights.side   <= RST_SIDE;
            r_weights.corner <= RST_CORNER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width          <= i_cfg_data[FW_W-1:0];
                CFG_HEIGHT: r_height         <= i_cfg_data[ROW_W-1:0];
                CFG_CENTRE: r_weights.centre <= i_cfg_data[WGT_W-1:0];
                CFG_SIDE:   r_weights.side   <= i_cfg_data[WGT_W-1:0];
                CFG_CORNER: r_weights.corner <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // width 0 acts as 1, above the buffer size acts as the buffer size
    always_comb begin
        if (r_width == '0) begin
            o_w_last = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            o_w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            o_w_last = COL_W'(32'(r_width) - 32'd1);
        end
    end

    // height 0 acts as 1
    assign o_h_last  = (r_height == '0) ? '0 : r_height - 16'd1;
    assign o_weights = r_weights;

endmodule

`default_nettype wire

[src/gb3_linebuf.sv]
// ----------------------------------------------------------------------------
// gb3_linebuf - two-row line buffer
// One word per column holds the two rows above; registered read with
// write-to-read forwarding when both hit the same column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gb3_linebuf
    import gb3_pkg::*;
#(
    parameter int AW = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output logic [LB_W-1:0]      o_rd_data,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire logic [LB_W-1:0] i_wr_data
);

    logic [LB_W-1:0] r_mem [2**AW];
    logic [LB_W-1:0] r_rd_data;

    // write port, and read port with forwarding of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[src/gb3_mac.sv]
// ----------------------------------------------------------------------------
// gb3_mac - weighted window sum
// Window register, product register, then sum, truncate and clamp into
// the output register. Each stage moves when the next one has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gb3_mac
    import gb3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_weights    i_weights,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_window     i_window,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_last
);

    logic        r_a_v, r_b_v, r_o_v;
    t_window     r_win;
    logic [23:0] r_pc;
    logic [25:0] r_pe, r_pk;
    logic        r_b_last;
    logic [PIX_W-1:0] r_pixel;
    logic        r_o_last;

    logic en_a, en_b, en_o;
    logic [9:0]  sides, corners;
    logic [23:0] n_pc;
    logic [25:0] n_pe, n_pk;
    logic [27:0] acc;
    logic [11:0] level;
    logic [PIX_W-1:0] n_pixel;

    // stage enables
    assign en_o    = !r_o_v || i_ready;
    assign en_b    = !r_b_v || en_o;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    // side and corner sums, then one product per weight
    assign sides   = 10'(r_win.tap[1]) + 10'(r_win.tap[3])
                   + 10'(r_win.tap[5]) + 10'(r_win.tap[7]);
    assign corners = 10'(r_win.tap[0]) + 10'(r_win.tap[2])
                   + 10'(r_win.tap[6]) + 10'(r_win.tap[8]);
    assign n_pc = 24'(i_weights.centre) * 24'(r_win.tap[4]);
    assign n_pe = 26'(i_weights.side) * 26'(sides);
    assign n_pk = 26'(i_weights.corner) * 26'(corners);

    // total, drop the fraction, clamp to the grey range
    assign acc     = 28'(r_pc) + 28'(r_pe) + 28'(r_pk);
    assign level   = acc[27:16];
    assign n_pixel = (level[11:8] != 4'd0) ? PIX_MAX : level[7:0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_valid;
            if (en_b) r_b_v <= r_a_v;
            if (en_o) r_o_v <= r_b_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_win <= i_window;
        end
        if (en_b) begin
            r_pc     <= n_pc;
            r_pe     <= n_pe;
            r_pk     <= n_pk;
            r_b_last <= r_win.last;
        end
        if (en_o) begin
            r_pixel  <= n_pixel;
            r_o_last <= r_b_last;
        end
    end

    assign o_valid = r_o_v;
    assign o_pixel = r_pixel;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

[src/gaussian_blur_3x3.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3 - streaming 3x3 Gaussian blur of 8-bit grey frames
//
// Slave stream: one transfer per item, tuser = operation (0 pixel, 1 drain),
// tdata = grey level. Master stream: tdata = filtered grey level, tlast
// marks the last pixel of the frame. Config channel: index and data,
// always ready; write only while the block is idle.
// A frame is width*height pixel transfers followed by width+1 drain
// transfers; the result for pixel k comes out on input transfer k+width+1,
// with edge pixels replicated at the borders. The input transfer that
// releases the tlast result returns all position counters to the frame start.
// Path: an input transfer reads the line buffer into the read stage,
// then the result it causes passes the window, product and output
// registers in turn (sum and clamp feed the output register).
// Throughput: one item per clock while the receiver holds tready high, set
// by the single-port-pair line buffer being read and written once per item.
// Reset: synchronous, active low; counters and valid bits clear, the
// config registers take their defaults, the line buffer keeps its content.
// Stall: while the receiver holds tready low, the pipeline fills its empty
// stages and keeps accepting until every stage holds a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_3x3
    import gb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] pixel_in
    input  wire logic                  i_s_tuser,   // [0] operation
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [7:0]                 o_m_tdata,   // [7:0] pixel_out
    output logic                       o_m_tlast,   // frame_last
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    t_weights         weights;

    // position counters
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W:0]   r_in_row;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    // line buffer read stage
    logic             r_s1_v;
    logic [COL_W-1:0] r_s1_col;
    logic [PIX_W-1:0] r_s1_px;
    logic             r_s1_emit;
    logic             r_s1_cfirst, r_s1_clast, r_s1_rfirst, r_s1_rlast, r_s1_last;

    // the two previous columns
    t_triple r_t1, r_t2;

    logic             s_xfer, s1_go, mac_ready;
    logic             in_frame, emit, last_pos;
    logic [PIX_W-1:0] n_px;
    logic [LB_W-1:0]  rd_data;
    t_triple          cur, left, mid, right;
    t_window          window;

    gb3_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_w_last    (w_last),
        .o_h_last    (h_last),
        .o_weights   (weights)
    );

    // handshake: the read stage moves on when its item needs no result
    // or the weighting pipeline has room
    assign s1_go      = r_s1_v && (!r_s1_emit || mac_ready);
    assign o_s_tready = !r_s1_v || s1_go;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    // what the incoming item stores and whether it releases a result
    assign in_frame = r_in_row <= {1'b0, h_last};
    assign n_px     = (in_frame && (i_s_tuser != OP_DRAIN)) ? i_s_tdata : '0;
    assign emit     = (r_in_row > 17'd1) || ((r_in_row == 17'd1) && (r_in_col != '0));
    assign last_pos = emit && (r_out_row == h_last) && (r_out_col == w_last);

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s_xfer) begin
            if (last_pos) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (r_in_col == w_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 17'd1;
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (emit) begin
                    if (r_out_col == w_last) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 16'd1;
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_v <= s_xfer;
        end
    end

    // read stage payload: column, stored pixel and border flags
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_col    <= r_in_col;
            r_s1_px     <= n_px;
            r_s1_emit   <= emit;
            r_s1_cfirst <= r_out_col == '0;
            r_s1_clast  <= r_out_col == w_last;
            r_s1_rfirst <= r_out_row == '0;
            r_s1_rlast  <= r_out_row == h_last;
            r_s1_last   <= last_pos;
        end
    end

    // low byte: row above, high byte: two rows above
    gb3_linebuf #(
        .AW (COL_W)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (s_xfer),
        .i_rd_addr (r_in_col),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[PIX_W-1:0], r_s1_px})
    );

    // column of the current item
    assign cur[0] = rd_data[LB_W-1:PIX_W];
    assign cur[1] = rd_data[PIX_W-1:0];
    assign cur[2] = r_s1_px;

    // column history
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_t2 <= r_t1;
            r_t1 <= cur;
        end
    end

    // horizontal replication at the left and right edges
    assign left  = r_s1_cfirst ? r_t1 : r_t2;
    assign mid   = r_t1;
    assign right = r_s1_clast ? r_t1 : cur;

    // vertical replication at the top and bottom rows
    always_comb begin
        window.tap[0] = r_s1_rfirst ? left[1]  : left[0];
        window.tap[1] = r_s1_rfirst ? mid[1]   : mid[0];
        window.tap[2] = r_s1_rfirst ? right[1] : right[0];
        window.tap[3] = left[1];
        window.tap[4] = mid[1];
        window.tap[5] = right[1];
        window.tap[6] = r_s1_rlast ? left[1]  : left[2];
        window.tap[7] = r_s1_rlast ? mid[1]   : mid[2];
        window.tap[8] = r_s1_rlast ? right[1] : right[2];
        window.last   = r_s1_last;
    end

    gb3_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_weights (weights),
        .i_valid   (r_s1_v && r_s1_emit),
        .o_ready   (mac_ready),
        .i_window  (window),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_pixel   (o_m_tdata),
        .o_last    (o_m_tlast)
    );

    // end of frame returns every position counter to the start
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && last_pos) |=>
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("position counters not cleared after the last pixel");

    // an empty output register never blocks the input side
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output register");

    // a window waiting for the weighting pipeline holds back the input
    a_window_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_emit && !mac_ready) |-> !o_s_tready)
        else $error("input transfer taken over a stalled window");

endmodule

`default_nettype wire

[bench/gaussian_blur_3x3_tb.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_tb - self-checking bench for the 3x3 Gaussian blur
// Walks a short table of hand-picked frames, then random small frames with
// random weights. Every accepted input transfer is run through a
// line-buffer predictor; output transfers are compared in order with its
// results. Both streams idle at random, and the result side holds off once
// for long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_blur_3x3_tb;
    import gb3_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int RING_LEN    = 2 * MAX_W + 4;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 460;
    localparam logic OP_PIXEL  = ~OP_DRAIN;

    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic             frame_end;
    } t_blurred_px;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // one step of the directed plan: a register write or an input transfer
    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  op;
        logic [PIX_W-1:0]      grey;
        logic                  typed;
        logic [PIX_W-1:0]      want_grey;
        logic                  want_end;
    } t_plan_row;

    // DUT connections
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [7:0]            o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state
    logic [PIX_W-1:0] ring_mem [RING_LEN];
    logic [FW_W-1:0]  cfg_width;
    logic [ROW_W-1:0] cfg_height;
    logic [WGT_W-1:0] cfg_centre;
    logic [WGT_W-1:0] cfg_side;
    logic [WGT_W-1:0] cfg_corner;
    int unsigned      in_col, in_row, out_col, out_row;

    // bench bookkeeping
    t_blurred_px blurred_q [$];
    t_blurred_px seen_px;
    t_plan_row   plan_q [$];
    int          err_count  = 0;
    int          items_sent = 0;
    bit          idle_on    = 1'b1;
    bit          hold_req   = 1'b0;

    gaussian_blur_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned eff_width(logic [FW_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_W) return MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height(logic [ROW_W-1:0] h);
        return (h == 0) ? 1 : h;
    endfunction

    function automatic int unsigned clamp_pos(int v, int unsigned lim);
        if (v < 0) return 0;
        if (v > int'(lim) - 1) return lim - 1;
        return v;
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight(int mode);
        unique case (mode)
            0:       return WGT_W'($urandom_range(0, 12000));
            1:       return WGT_W'($urandom);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // register write into the predictor
    task automatic cfg_update(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        unique case (idx)
            CFG_WIDTH:  cfg_width  = v[FW_W-1:0];
            CFG_HEIGHT: cfg_height = v;
            CFG_CENTRE: cfg_centre = v;
            CFG_SIDE:   cfg_side   = v;
            CFG_CORNER: cfg_corner = v;
            default: ;
        endcase
    endtask

    // line-buffer predictor: one input item in, at most one filtered pixel out
    task automatic blur_step(input logic op, input logic [PIX_W-1:0] grey,
                             output logic got, output t_blurred_px res);
        int unsigned      w, h, rr, cc;
        longint unsigned  lin_in, lin, sides, corners, acc;
        logic [PIX_W-1:0] taps [9];
        w   = eff_width(cfg_width);
        h   = eff_height(cfg_height);
        got = 1'b0;
        res = '0;
        lin_in = longint'(in_row) * w + in_col;
        // drains inside the frame store black; nothing is stored after it
        if (in_row < h)
            ring_mem[lin_in % RING_LEN] = (op == OP_DRAIN) ? '0 : grey;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (lin_in >= longint'(w) + 1) begin
            // gather the window with the border rows and columns replicated
            for (int dr = 0; dr < 3; dr++) begin
                rr = clamp_pos(int'(out_row) + dr - 1, h);
                for (int dc = 0; dc < 3; dc++) begin
                    cc  = clamp_pos(int'(out_col) + dc - 1, w);
                    lin = longint'(rr) * w + cc;
                    taps[dr * 3 + dc] = ring_mem[lin % RING_LEN];
                end
            end
            sides   = taps[1] + taps[3] + taps[5] + taps[7];
            corners = taps[0] + taps[2] + taps[6] + taps[8];
            acc = cfg_centre * taps[4] + cfg_side * sides + cfg_corner * corners;
            acc = acc >> 16;
            got           = 1'b1;
            res.grey      = (acc > PIX_MAX) ? PIX_MAX : acc[PIX_W-1:0];
            res.frame_end = (out_row >= h - 1) && (out_col >= w - 1);
            // end of frame sends every counter back to the start
            if (res.frame_end) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    // offer one input transfer and log what it should produce
    task automatic push_item(input logic op, input logic [PIX_W-1:0] grey,
                             input logic typed, input logic [PIX_W-1:0] want_grey,
                             input logic want_end);
        int          gap;
        logic        got;
        t_blurred_px res;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= grey;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        blur_step(op, grey, got, res);
        if (typed)
            blurred_q.push_back('{grey: want_grey, frame_end: want_end});
        else if (got)
            blurred_q.push_back(res);
        items_sent++;
    endtask

    // let the pipeline empty before touching the registers
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_update(idx, v);
    endtask

    task automatic load_settings(logic [FW_W-1:0] w, logic [ROW_W-1:0] h,
                                 logic [WGT_W-1:0] c, logic [WGT_W-1:0] s,
                                 logic [WGT_W-1:0] k);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CENTRE, c);
        write_reg(CFG_SIDE, s);
        write_reg(CFG_CORNER, k);
    endtask

    // whole frame of random content plus its flush tail
    task automatic send_frame();
        int unsigned w, h;
        logic        op;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        for (int unsigned n = 0; n < w * h; n++) begin
            op = ($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_PIXEL;
            push_item(op, PIX_W'($urandom), 1'b0, '0, 1'b0);
        end
        // tail mixes drains with pixel transfers, which count as drains here
        for (int unsigned n = 0; n <= w; n++)
            push_item(1'($urandom), PIX_W'($urandom), 1'b0, '0, 1'b0);
    endtask

    task automatic add_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        plan_q.push_back('{kind: ROW_CFG, reg_idx: idx, reg_val: v, default: '0});
    endtask

    task automatic add_item(logic op, logic [PIX_W-1:0] grey);
        plan_q.push_back('{kind: ROW_ITEM, reg_idx: CFG_WIDTH, op: op, grey: grey,
                           default: '0});
    endtask

    task automatic add_typed(logic op, logic [PIX_W-1:0] grey,
                             logic [PIX_W-1:0] want_grey, logic want_end);
        plan_q.push_back('{kind: ROW_ITEM, reg_idx: CFG_WIDTH, op: op, grey: grey,
                           typed: 1'b1, want_grey: want_grey, want_end: want_end,
                           default: '0});
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                if (idle_on) stall_left = pick_gap();
            end
        end
    end

    // compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (blurred_q.size() == 0) begin
                $error("unexpected output transfer: pixel_out %0d frame_last %0b",
                       o_m_tdata, o_m_tlast);
                err_count++;
            end else begin
                seen_px = blurred_q.pop_front();
                if (o_m_tdata !== seen_px.grey) begin
                    $error("pixel_out: expected %0d, got %0d", seen_px.grey, o_m_tdata);
                    err_count++;
                end
                if (o_m_tlast !== seen_px.frame_end) begin
                    $error("frame_last: expected %0b, got %0b",
                           seen_px.frame_end, o_m_tlast);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int mode;
        // predictor starts from the reset state
        cfg_width  = RST_WIDTH;
        cfg_height = RST_HEIGHT;
        cfg_centre = RST_CENTRE;
        cfg_side   = RST_SIDE;
        cfg_corner = RST_CORNER;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        foreach (ring_mem[i]) ring_mem[i] = '0;

        // 3x2 frame on reset weights: drain inside, pixels in the tail
        add_cfg(CFG_WIDTH, 16'd3);
        add_cfg(CFG_HEIGHT, 16'd2);
        add_item(OP_PIXEL, 8'h00);
        add_item(OP_PIXEL, 8'hFF);
        add_item(OP_DRAIN, 8'h3C);
        add_item(OP_PIXEL, 8'h55);
        add_item(OP_PIXEL, 8'hAA);
        add_item(OP_PIXEL, 8'h01);
        add_item(OP_DRAIN, 8'h80);
        add_item(OP_PIXEL, 8'h7E);
        add_item(OP_DRAIN, 8'hC3);
        add_item(OP_PIXEL, 8'hFF);
        // 2x2 white frame, full weights: every output saturates
        add_cfg(CFG_WIDTH, 16'd2);
        add_cfg(CFG_HEIGHT, 16'd2);
        add_cfg(CFG_CENTRE, 16'hFFFF);
        add_cfg(CFG_SIDE, 16'hFFFF);
        add_cfg(CFG_CORNER, 16'hFFFF);
        add_item(OP_PIXEL, 8'hFF);
        add_item(OP_PIXEL, 8'hFF);
        add_item(OP_PIXEL, 8'hFF);
        add_typed(OP_PIXEL, 8'hFF, 8'd255, 1'b0);
        add_typed(OP_DRAIN, 8'h00, 8'd255, 1'b0);
        add_typed(OP_DRAIN, 8'h5A, 8'd255, 1'b0);
        add_typed(OP_DRAIN, 8'hA5, 8'd255, 1'b1);
        // zero width and height act as one pixel; zero weights give black
        add_cfg(CFG_WIDTH, 16'd0);
        add_cfg(CFG_HEIGHT, 16'd0);
        add_cfg(CFG_CENTRE, 16'd0);
        add_cfg(CFG_SIDE, 16'd0);
        add_cfg(CFG_CORNER, 16'd0);
        add_item(OP_PIXEL, 8'hFF);
        add_item(OP_DRAIN, 8'hFF);
        add_typed(OP_DRAIN, 8'hFF, 8'd0, 1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        foreach (plan_q[i]) begin
            if (plan_q[i].kind == ROW_CFG)
                write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
            else
                push_item(plan_q[i].op, plan_q[i].grey, plan_q[i].typed,
                          plan_q[i].want_grey, plan_q[i].want_end);
        end

        // back-pressure: sender runs flat out while the result side holds off
        load_settings(11'd16, 16'd8, RST_CENTRE, RST_SIDE, RST_CORNER);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        send_frame();

        // random small frames
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            mode = $urandom_range(0, 3);
            load_settings(($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 12)),
                          ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                          pick_weight(mode), pick_weight(mode), pick_weight(mode));
            idle_on = ($urandom_range(0, 3) != 0);
            send_frame();
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
src/gb3_pkg.sv
src/gb3_cfg.sv
src/gb3_linebuf.sv
src/gb3_mac.sv
src/gaussian_blur_3x3.sv
bench/gaussian_blur_3x3_tb.sv
